[hw/rtl/qadd_pkg.sv]
package qadd_pkg;

  // pipeline shape
  localparam int NUM_STAGES         = 15;
  localparam int DIV_ITER_STAGES    = 7;
  localparam int DIV_BITS_PER_STAGE = 4;

  // register indexes
  localparam logic [2:0] REG_SCALE_A      = 3'd0;
  localparam logic [2:0] REG_SCALE_B      = 3'd1;
  localparam logic [2:0] REG_SCALE_RESULT = 3'd2;
  localparam logic [2:0] REG_CLAMP_LOW    = 3'd3;
  localparam logic [2:0] REG_CLAMP_HIGH   = 3'd4;

  // float32 constants
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX = 8'hFF;

  // special value flags carried beside a datapath
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } fp_class_t;

  // position of the highest set bit
  function automatic logic [4:0] lead32(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // round to nearest even and pack; sig has its leading one at bit 26,
  // bits 2..0 are guard, round and sticky; e is the biased exponent
  function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                           input logic [26:0] sig);
    logic [11:0] sh;
    logic [26:0] mask;
    logic [26:0] m27;
    logic        inc;
    logic [24:0] m;
    logic [11:0] ex;
    logic [31:0] res;
    if (e < 12'sd1) begin
      sh = 12'(12'sd1 - e);
      if (sh > 12'd27) sh = 12'd27;
      mask = ~(27'h7FF_FFFF << sh[4:0]);
      m27  = (sig >> sh[4:0]) | {26'd0, |(sig & mask)};
      ex   = 12'd0;
    end else begin
      m27 = sig;
      ex  = 12'(e);
    end
    inc = m27[2] & (m27[1] | m27[0] | m27[3]);
    m   = {1'b0, m27[26:3]} + {24'd0, inc};
    if (ex == 12'd0) begin
      res = {s, 7'd0, m[23:0]};
    end else begin
      if (m[24]) ex = ex + 12'd1;
      if (ex >= 12'd255) res = {s, EXP_MAX, 23'd0};
      else res = {s, ex[7:0], m[22:0]};
    end
    return res;
  endfunction

endpackage

[hw/rtl/qadd_fmul.sv]
module qadd_fmul (
  input  logic              clk,
  input  logic [1:0]        en,
  input  logic signed [7:0] elem,
  input  logic [31:0]       scale,
  output logic [31:0]       prod_bits
);

  logic [7:0]         mag;
  logic [7:0]         sc_e;
  logic [23:0]        sc_sig;
  qadd_pkg::fp_class_t cls_next;
  logic [31:0]        prod_next;
  logic signed [11:0] exp_next;

  logic [31:0]         s1_prod;
  qadd_pkg::fp_class_t s1_cls;
  logic signed [11:0]  s1_exp;

  // integer magnitude times scale significand, special cases
  always_comb begin
    mag       = elem[7] ? 8'(-elem) : 8'(elem);
    sc_e      = scale[30:23];
    sc_sig    = {|sc_e, scale[22:0]};
    prod_next = {24'd0, mag} * {8'd0, sc_sig};
    exp_next  = (sc_e == 8'd0) ? 12'sd1 : $signed({4'd0, sc_e});
    cls_next.nan  = (&sc_e) & ((|scale[22:0]) | (mag == 8'd0));
    cls_next.inf  = (&sc_e) & ~cls_next.nan;
    cls_next.zero = 1'b0;
    cls_next.sign = elem[7] ^ scale[31];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_prod <= prod_next;
      s1_cls  <= cls_next;
      s1_exp  <= exp_next;
    end
  end

  // normalise product and round
  logic [4:0]         p;
  logic [4:0]         sh;
  logic [31:0]        mask;
  logic [26:0]        norm;
  logic signed [11:0] e_norm;
  logic [31:0]        bits_next;

  always_comb begin
    p    = qadd_pkg::lead32(s1_prod);
    sh   = 5'd0;
    mask = 32'd0;
    if (p >= 5'd26) begin
      sh   = p - 5'd26;
      mask = ~(32'hFFFF_FFFF << sh);
      norm = 27'(s1_prod >> sh) | {26'd0, |(s1_prod & mask)};
    end else begin
      norm = 27'(s1_prod << (5'd26 - p));
    end
    e_norm = $signed({7'd0, p}) + s1_exp - 12'sd23;
    if (s1_cls.nan) bits_next = qadd_pkg::FP_QNAN;
    else if (s1_cls.inf) bits_next = {s1_cls.sign, qadd_pkg::EXP_MAX, 23'd0};
    else if (s1_prod == 32'd0) bits_next = {s1_cls.sign, 31'd0};
    else bits_next = qadd_pkg::fp_round(s1_cls.sign, e_norm, norm);
  end

  always_ff @(posedge clk) begin
    if (en[1]) prod_bits <= bits_next;
  end

endmodule

[hw/rtl/qadd_fadd.sv]
module qadd_fadd (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [31:0] x_bits,
  input  logic [31:0] y_bits,
  output logic [31:0] sum_bits
);

  // unpack, order by magnitude, align the smaller operand
  logic                x_nan, y_nan, x_inf, y_inf, swap;
  logic [31:0]         big, little;
  logic [7:0]          b_eb, s_eb, d;
  logic [26:0]         b27, s27, al, mask;
  qadd_pkg::fp_class_t cls_next;

  always_comb begin
    x_nan  = (&x_bits[30:23]) & (|x_bits[22:0]);
    y_nan  = (&y_bits[30:23]) & (|y_bits[22:0]);
    x_inf  = (&x_bits[30:23]) & ~(|x_bits[22:0]);
    y_inf  = (&y_bits[30:23]) & ~(|y_bits[22:0]);
    swap   = y_bits[30:0] > x_bits[30:0];
    big    = swap ? y_bits : x_bits;
    little = swap ? x_bits : y_bits;
    b_eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    s_eb   = (little[30:23] == 8'd0) ? 8'd1 : little[30:23];
    d      = b_eb - s_eb;
    b27    = {|big[30:23], big[22:0], 3'b000};
    s27    = {|little[30:23], little[22:0], 3'b000};
    mask   = 27'd0;
    if (d >= 8'd27) begin
      al = {26'd0, |s27};
    end else begin
      mask = ~(27'h7FF_FFFF << d[4:0]);
      al   = (s27 >> d[4:0]) | {26'd0, |(s27 & mask)};
    end
    cls_next.nan  = x_nan | y_nan | (x_inf & y_inf & (x_bits[31] ^ y_bits[31]));
    cls_next.inf  = ~cls_next.nan & (x_inf | y_inf);
    cls_next.zero = 1'b0;
    if (x_inf | y_inf) cls_next.sign = x_inf ? x_bits[31] : y_bits[31];
    else cls_next.sign = big[31];
  end

  qadd_pkg::fp_class_t a1_cls;
  logic                a1_sub;
  logic [26:0]         a1_big, a1_small;
  logic [7:0]          a1_e;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1_cls   <= cls_next;
      a1_sub   <= x_bits[31] ^ y_bits[31];
      a1_big   <= b27;
      a1_small <= al;
      a1_e     <= b_eb;
    end
  end

  // add or subtract, then normalise
  logic [27:0]         r;
  logic [4:0]          p, lsh;
  logic [26:0]         n;
  logic signed [11:0]  e_n;
  qadd_pkg::fp_class_t cls2;

  always_comb begin
    r    = a1_sub ? ({1'b0, a1_big} - {1'b0, a1_small})
                  : ({1'b0, a1_big} + {1'b0, a1_small});
    p    = qadd_pkg::lead32({4'd0, r});
    lsh  = 5'd26 - p;
    cls2 = a1_cls;
    if (r[27]) begin
      n   = {r[27:2], r[1] | r[0]};
      e_n = $signed({4'd0, a1_e}) + 12'sd1;
    end else begin
      n   = r[26:0] << lsh;
      e_n = $signed({4'd0, a1_e}) - $signed({7'd0, lsh});
    end
    cls2.zero = (r == 28'd0) & ~a1_cls.nan & ~a1_cls.inf;
    if (cls2.zero) cls2.sign = a1_sub ? 1'b0 : a1_cls.sign;
  end

  qadd_pkg::fp_class_t a2_cls;
  logic [26:0]         a2_sig;
  logic signed [11:0]  a2_e;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a2_cls <= cls2;
      a2_sig <= n;
      a2_e   <= e_n;
    end
  end

  // round and pack
  logic [31:0] bits_next;

  always_comb begin
    if (a2_cls.nan) bits_next = qadd_pkg::FP_QNAN;
    else if (a2_cls.inf) bits_next = {a2_cls.sign, qadd_pkg::EXP_MAX, 23'd0};
    else if (a2_cls.zero) bits_next = {a2_cls.sign, 31'd0};
    else bits_next = qadd_pkg::fp_round(a2_cls.sign, a2_e, a2_sig);
  end

  always_ff @(posedge clk) begin
    if (en[2]) sum_bits <= bits_next;
  end

endmodule

[hw/rtl/qadd_fdiv.sv]
module qadd_fdiv (
  input  logic        clk,
  input  logic [8:0]  en,
  input  logic [31:0] num_bits,
  input  logic [31:0] den_bits,
  output logic [31:0] quot_bits
);

  localparam int NI = qadd_pkg::DIV_ITER_STAGES;

  // unpack, special cases, normalise subnormal significands
  logic                x_nan, y_nan, x_inf, y_inf, x_z, y_z;
  logic [23:0]         sx, sy, mx, my;
  logic [4:0]          shx, shy;
  logic [7:0]          ebx, eby;
  logic signed [11:0]  e_next;
  qadd_pkg::fp_class_t cls_next;

  always_comb begin
    x_nan = (&num_bits[30:23]) & (|num_bits[22:0]);
    y_nan = (&den_bits[30:23]) & (|den_bits[22:0]);
    x_inf = (&num_bits[30:23]) & ~(|num_bits[22:0]);
    y_inf = (&den_bits[30:23]) & ~(|den_bits[22:0]);
    x_z   = num_bits[30:0] == 31'd0;
    y_z   = den_bits[30:0] == 31'd0;
    sx    = {|num_bits[30:23], num_bits[22:0]};
    sy    = {|den_bits[30:23], den_bits[22:0]};
    shx   = 5'd23 - qadd_pkg::lead32({8'd0, sx});
    shy   = 5'd23 - qadd_pkg::lead32({8'd0, sy});
    mx    = sx << shx;
    my    = sy << shy;
    ebx   = (num_bits[30:23] == 8'd0) ? 8'd1 : num_bits[30:23];
    eby   = (den_bits[30:23] == 8'd0) ? 8'd1 : den_bits[30:23];
    e_next = $signed({4'd0, ebx}) - $signed({7'd0, shx}) - $signed({4'd0, eby})
           + $signed({7'd0, shy}) + 12'sd127;
    cls_next.nan  = x_nan | y_nan | (x_z & y_z) | (x_inf & y_inf);
    cls_next.inf  = ~cls_next.nan & (x_inf | y_z);
    cls_next.zero = ~cls_next.nan & ~cls_next.inf & (x_z | y_inf);
    cls_next.sign = num_bits[31] ^ den_bits[31];
  end

  // stage registers; index 0 is the setup stage
  logic [24:0]         it_r   [NI+1];
  logic [27:0]         it_q   [NI+1];
  logic [23:0]         it_my  [NI+1];
  logic signed [11:0]  it_e   [NI+1];
  qadd_pkg::fp_class_t it_cls [NI+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      it_r[0]   <= {1'b0, mx};
      it_q[0]   <= 28'd0;
      it_my[0]  <= my;
      it_e[0]   <= e_next;
      it_cls[0] <= cls_next;
    end
  end

  // restoring division, DIV_BITS_PER_STAGE (4) quotient bits per stage
  for (genvar g = 0; g < NI; g++) begin : g_iter
    logic [24:0] r_step;
    logic [27:0] q_step;

    always_comb begin
      r_step = it_r[g];
      q_step = it_q[g];
      for (int k = 0; k < qadd_pkg::DIV_BITS_PER_STAGE; k++) begin
        if (r_step >= {1'b0, it_my[g]}) begin
          r_step = r_step - {1'b0, it_my[g]};
          q_step = {q_step[26:0], 1'b1};
        end else begin
          q_step = {q_step[26:0], 1'b0};
        end
        r_step = {r_step[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en[g+1]) begin
        it_r[g+1]   <= r_step;
        it_q[g+1]   <= q_step;
        it_my[g+1]  <= it_my[g];
        it_e[g+1]   <= it_e[g];
        it_cls[g+1] <= it_cls[g];
      end
    end
  end

  // pick the leading quotient bit, round and pack
  logic                rem;
  logic [27:0]         q;
  logic [26:0]         sig;
  logic signed [11:0]  e_q;
  qadd_pkg::fp_class_t cls_q;
  logic [31:0]         bits_next;

  always_comb begin
    q     = it_q[NI];
    rem   = |it_r[NI];
    cls_q = it_cls[NI];
    if (q[27]) begin
      sig = {q[27:2], q[1] | q[0] | rem};
      e_q = it_e[NI];
    end else begin
      sig = {q[26:1], q[0] | rem};
      e_q = it_e[NI] - 12'sd1;
    end
    if (cls_q.nan) bits_next = qadd_pkg::FP_QNAN;
    else if (cls_q.inf) bits_next = {cls_q.sign, qadd_pkg::EXP_MAX, 23'd0};
    else if (cls_q.zero) bits_next = {cls_q.sign, 31'd0};
    else bits_next = qadd_pkg::fp_round(cls_q.sign, e_q, sig);
  end

  always_ff @(posedge clk) begin
    if (en[NI+1]) quot_bits <= bits_next;
  end

endmodule

[hw/rtl/qadd_fcvt.sv]
module qadd_fcvt (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       quot_bits,
  input  logic signed [7:0] clamp_low,
  input  logic signed [7:0] clamp_high,
  output logic signed [7:0] value
);

  logic [7:0]         qe;
  logic               nan;
  logic               s;
  logic [9:0]         t;
  logic [9:0]         mag;
  logic signed [9:0]  r;
  logic signed [9:0]  lo, hi;

  // round half away from zero, saturate, clamp to the bounds
  always_comb begin
    qe  = quot_bits[30:23];
    s   = quot_bits[31];
    nan = (&qe) & (|quot_bits[22:0]);
    t   = 10'd0;
    mag = 10'd0;
    if (nan) begin
      r = 10'sd256;
    end else if (qe >= 8'd135) begin
      r = s ? -10'sd256 : 10'sd256;
    end else if (qe < 8'd126) begin
      r = 10'sd0;
    end else begin
      t   = 10'({1'b1, quot_bits[22:0]} >> (8'd149 - qe));
      mag = (t + 10'd1) >> 1;
      r   = s ? $signed(10'(-mag)) : $signed(mag);
    end
    lo = {{2{clamp_low[7]}}, clamp_low};
    hi = {{2{clamp_high[7]}}, clamp_high};
    if (r < lo) r = lo;
    if (r > hi) r = hi;
  end

  always_ff @(posedge clk) begin
    if (en) value <= r[7:0];
  end

endmodule

[hw/rtl/quantized_int8_add_float_scaled_unit.sv]
// Quantized int8 elementwise add with float32 scaling.
// Input channel: in_valid / in_stall carry one beat per element pair
// (elem_a, elem_b, last_elem). Output channel: out_valid / out_stall carry
// one beat per result (sum_value, sum_last), in input order.
// Each beat gives (a*scale_a + b*scale_b) / scale_result in float32, every
// step rounded separately, then rounded half away from zero and clamped to
// [clamp_low, clamp_high].
// Throughput: one beat per cycle unless out_stall holds the pipeline; the
// 15 stages are float multiply (2), float add (3), divider setup, 7 divider
// stages of 4 quotient bits each, divider rounding, and integer conversion
// into the output register.
// Stall: each stage holds its beat while the one after it is full and held,
// so empty stages keep filling while a result waits; in_stall rises only
// when every stage is occupied and out_stall is high.
// Reset (rst, synchronous): empties the pipeline and sets the scales to 1.0
// and the bounds to -128 and 127. Indexes above 4 are dropped. The user must
// write registers via cfg_write, cfg_index, cfg_data only when idle (unenforced).
module quantized_int8_add_float_scaled_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] elem_a,
  input  logic signed [7:0] elem_b,
  input  logic              last_elem,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] sum_value,
  output logic              sum_last
);

  localparam int NS = qadd_pkg::NUM_STAGES;

  // configuration registers
  logic [31:0]       scale_in_a_bits;
  logic [31:0]       scale_in_b_bits;
  logic [31:0]       scale_result_bits;
  logic signed [7:0] clamp_low;
  logic signed [7:0] clamp_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_in_a_bits   <= qadd_pkg::FP_ONE;
      scale_in_b_bits   <= qadd_pkg::FP_ONE;
      scale_result_bits <= qadd_pkg::FP_ONE;
      clamp_low         <= -8'sd128;
      clamp_high        <= 8'sd127;
    end else if (cfg_write) begin
      unique case (cfg_index)
        qadd_pkg::REG_SCALE_A:      scale_in_a_bits   <= cfg_data;
        qadd_pkg::REG_SCALE_B:      scale_in_b_bits   <= cfg_data;
        qadd_pkg::REG_SCALE_RESULT: scale_result_bits <= cfg_data;
        qadd_pkg::REG_CLAMP_LOW:    clamp_low         <= cfg_data[7:0];
        qadd_pkg::REG_CLAMP_HIGH:   clamp_high        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] last_pipe;

  always_comb begin
    en[NS-1] = ~v[NS-1] | ~out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = ~v[i] | en[i+1];
    end
  end

  assign in_stall = ~en[0];

  // valid bits and last flag travel with the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) last_pipe[0] <= last_elem;
    for (int i = 1; i < NS; i++) begin
      if (en[i]) last_pipe[i] <= last_pipe[i-1];
    end
  end

  // datapath
  logic [31:0] prod_a, prod_b, sum_bits, quot_bits;

  qadd_fmul u_mul_a (
    .clk       (clk),
    .en        (en[1:0]),
    .elem      (elem_a),
    .scale     (scale_in_a_bits),
    .prod_bits (prod_a)
  );

  qadd_fmul u_mul_b (
    .clk       (clk),
    .en        (en[1:0]),
    .elem      (elem_b),
    .scale     (scale_in_b_bits),
    .prod_bits (prod_b)
  );

  qadd_fadd u_add (
    .clk      (clk),
    .en       (en[4:2]),
    .x_bits   (prod_a),
    .y_bits   (prod_b),
    .sum_bits (sum_bits)
  );

  qadd_fdiv u_div (
    .clk       (clk),
    .en        (en[13:5]),
    .num_bits  (sum_bits),
    .den_bits  (scale_result_bits),
    .quot_bits (quot_bits)
  );

  qadd_fcvt u_cvt (
    .clk        (clk),
    .en         (en[14]),
    .quot_bits  (quot_bits),
    .clamp_low  (clamp_low),
    .clamp_high (clamp_high),
    .value      (sum_value)
  );

  assign out_valid = v[NS-1];
  assign sum_last  = last_pipe[NS-1];

  // checks
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&v))
    else $error("input stalled with an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> v[0])
    else $error("accepted beat missing from first stage");

  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    (v[NS-2] && en[NS-1]) |=> out_valid)
    else $error("beat lost entering output register");

endmodule
